// ===== design/rvsw_pkg.sv =====
// Shared widths and constants for the ray voxel step walker.
`default_nettype none
package rvsw_pkg;

  localparam int DIR_W         = 16;  // signed Q1.15 direction component
  localparam int LEN_W         = 7;   // ray length field
  localparam int OFF_W         = 8;   // voxel offset, wraps
  localparam int IDX_W         = 6;   // step index, wraps
  localparam int DLT_W         = 32;  // unsigned Q16.16 reciprocal, up to 2^31
  localparam int ACC_W         = 40;  // holds seed plus 255 deltas
  localparam int MAX_STEPS_DEF = 64;

endpackage
`default_nettype wire

// ===== design/ray_voxel_step_walker.sv =====
// Top level of the ray voxel step walker (3D DDA traversal from the origin voxel center).
// An item is taken when start is high and busy is low. The block first forms the three
// per-axis reciprocals 2^31/|dir| on one shared divider that retires two quotient bits a
// cycle, one axis after another, then walks one voxel per cycle; an item with effective
// length n keeps busy high until its n-th voxel is walked. Each position appears on the
// out_ ports for exactly one cycle with out_valid high; the receiver cannot stall, so it
// must take every result as it comes. A length of zero produces no result and busy stays low.
`default_nettype none
module ray_voxel_step_walker #(
  parameter int MAX_STEPS = rvsw_pkg::MAX_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [rvsw_pkg::DIR_W-1:0] in_dir_x,
  input  wire logic signed [rvsw_pkg::DIR_W-1:0] in_dir_y,
  input  wire logic signed [rvsw_pkg::DIR_W-1:0] in_dir_z,
  input  wire logic [rvsw_pkg::LEN_W-1:0]        in_ray_length,
  output logic                                   out_valid,
  output logic signed [rvsw_pkg::OFF_W-1:0]      out_offset_x,
  output logic signed [rvsw_pkg::OFF_W-1:0]      out_offset_y,
  output logic signed [rvsw_pkg::OFF_W-1:0]      out_offset_z,
  output logic [rvsw_pkg::IDX_W-1:0]             out_step_index,
  output logic                                   out_last_step
);

  localparam int DW  = rvsw_pkg::DIR_W;
  localparam int AW  = rvsw_pkg::ACC_W;
  localparam int QW  = rvsw_pkg::DLT_W;
  localparam int OW  = rvsw_pkg::OFF_W;
  localparam int NW  = $clog2(MAX_STEPS + 1);
  localparam int CW  = (NW > rvsw_pkg::LEN_W) ? NW : rvsw_pkg::LEN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  logic [1:0]    state_r;
  logic [1:0]    axis_r;
  logic          go_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] i_r;

  logic [DW-1:0] mag_r  [3];
  logic          neg_r  [3];
  logic [QW-1:0] dlt_r  [3];
  logic [AW-1:0] acc_r  [3];
  logic          inf_r  [3];
  logic [OW-1:0] pos_r  [3];

  logic          out_valid_r, out_last_r;
  logic [OW-1:0] out_x_r, out_y_r, out_z_r;
  logic [rvsw_pkg::IDX_W-1:0] out_idx_r;

  logic          div_done;
  logic [QW-1:0] div_quot;

  logic                  accept;
  logic [DW-1:0]         dir_in [3];
  logic [CW-1:0]         len_ext, len_cap;
  logic                  x_lt_y, x_lt_z, y_lt_z;
  logic [2:0]            sel;
  logic [NW-1:0]         i_inc;
  logic                  is_last;

  rvsw_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go_r),
    .divisor (mag_r[axis_r]),
    .done    (div_done),
    .quot    (div_quot)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    dir_in[0] = in_dir_x;
    dir_in[1] = in_dir_y;
    dir_in[2] = in_dir_z;
    len_ext   = CW'(in_ray_length);
    len_cap   = (len_ext > CW'(MAX_STEPS)) ? CW'(MAX_STEPS) : len_ext;
  end

  // Infinite accumulators compare greater than any finite one and equal to each other.
  function automatic logic acc_lt(input logic ia, input logic [AW-1:0] a,
                                  input logic ib, input logic [AW-1:0] b);
    acc_lt = !ia && (ib || (a < b));
  endfunction

  always_comb begin
    x_lt_y  = acc_lt(inf_r[0], acc_r[0], inf_r[1], acc_r[1]);
    x_lt_z  = acc_lt(inf_r[0], acc_r[0], inf_r[2], acc_r[2]);
    y_lt_z  = acc_lt(inf_r[1], acc_r[1], inf_r[2], acc_r[2]);
    sel     = 3'b100;
    if (x_lt_y && x_lt_z) begin
      sel = 3'b001;
    end else if (y_lt_z) begin
      sel = 3'b010;
    end
    i_inc   = i_r + NW'(1);
    is_last = (i_inc == n_r);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= AX_X;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept && (len_cap != '0)) begin
            state_r <= ST_DIV;
            axis_r  <= AX_X;
            go_r    <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (axis_r == AX_Z) begin
              state_r <= ST_WALK;
            end else begin
              axis_r <= (axis_r == AX_X) ? AX_Y : AX_Z;
              go_r   <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          out_valid_r <= 1'b1;
          if (is_last) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      n_r <= NW'(len_cap);
      i_r <= '0;
      for (int a = 0; a < 3; a++) begin
        mag_r[a] <= dir_in[a][DW-1] ? (~dir_in[a] + DW'(1)) : dir_in[a];
        neg_r[a] <= dir_in[a][DW-1];
        pos_r[a] <= '0;
      end
    end else if (state_r == ST_DIV && div_done) begin
      dlt_r[axis_r] <= div_quot;
      acc_r[axis_r] <= AW'(div_quot >> 1);
      inf_r[axis_r] <= (mag_r[axis_r] == '0);
    end else if (state_r == ST_WALK) begin
      i_r <= i_inc;
      for (int a = 0; a < 3; a++) begin
        if (sel[a]) begin
          if (mag_r[a] != '0) begin
            pos_r[a] <= neg_r[a] ? (pos_r[a] - OW'(1)) : (pos_r[a] + OW'(1));
          end
          if (!inf_r[a]) begin
            acc_r[a] <= acc_r[a] + AW'(dlt_r[a]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WALK) begin
      out_x_r    <= pos_r[0];
      out_y_r    <= pos_r[1];
      out_z_r    <= pos_r[2];
      out_idx_r  <= i_r[rvsw_pkg::IDX_W-1:0];
      out_last_r <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_offset_x   = out_x_r;
  assign out_offset_y   = out_y_r;
  assign out_offset_z   = out_z_r;
  assign out_step_index = out_idx_r;
  assign out_last_step  = out_last_r;

endmodule
`default_nettype wire

// ===== design/rvsw_div.sv =====
// Radix-4 restoring divider: quotient of 2^31 by a 16-bit magnitude, two bits a cycle.
`default_nettype none
module rvsw_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire logic [rvsw_pkg::DIR_W-1:0] divisor,
  output logic                            done,
  output logic [rvsw_pkg::DLT_W-1:0]      quot
);

  localparam int ITER  = rvsw_pkg::DLT_W / 2;
  localparam int CNT_W = $clog2(ITER);
  localparam int DW    = rvsw_pkg::DIR_W;

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r;
  logic [rvsw_pkg::DLT_W-1:0] quot_r;

  logic          b1, q1, q2;
  logic [DW:0]   t1, t2, d_ext, r1;
  logic [DW:0]   r2;

  // Dividend is 2^31: only the first bit shifted in is a one.
  always_comb begin
    b1    = (cnt_r == '0);
    d_ext = {1'b0, divisor};
    t1    = {rem_r, b1};
    q1    = (t1 >= d_ext);
    r1    = q1 ? (t1 - d_ext) : t1;
    t2    = {r1[DW-1:0], 1'b0};
    q2    = (t2 >= d_ext);
    r2    = q2 ? (t2 - d_ext) : t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ITER - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
    end else if (run_r) begin
      rem_r  <= r2[DW-1:0];
      quot_r <= {quot_r[rvsw_pkg::DLT_W-3:0], q1, q2};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

// ===== design/rvsw_checker.sv =====
// Port-level checks for the ray voxel step walker, bound to the top level.
`default_nettype none
module rvsw_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [rvsw_pkg::LEN_W-1:0]   in_ray_length,
  input wire logic                         out_valid,
  input wire logic [rvsw_pkg::OFF_W-1:0]   out_offset_x,
  input wire logic [rvsw_pkg::OFF_W-1:0]   out_offset_y,
  input wire logic [rvsw_pkg::OFF_W-1:0]   out_offset_z,
  input wire logic [rvsw_pkg::IDX_W-1:0]   out_step_index,
  input wire logic                         out_last_step
);

  // A nonzero length starts a walk.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_ray_length != '0) |=> busy)
    else $error("accepted item did not raise busy");

  // Results of one ray come in consecutive cycles.
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_step) |=> out_valid)
    else $error("gap inside a ray's results");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_step) |=>
      (out_step_index == $past(out_step_index) + rvsw_pkg::IDX_W'(1)))
    else $error("step index not incrementing");

  // Every ray opens at the origin voxel with index zero.
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |->
      (out_offset_x == '0 && out_offset_y == '0 && out_offset_z == '0 &&
       out_step_index == '0))
    else $error("first result not at origin");

  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_step) |-> busy)
    else $error("idle while results remain");

endmodule

bind ray_voxel_step_walker rvsw_checker u_rvsw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_ray_length  (in_ray_length),
  .out_valid      (out_valid),
  .out_offset_x   (out_offset_x),
  .out_offset_y   (out_offset_y),
  .out_offset_z   (out_offset_z),
  .out_step_index (out_step_index),
  .out_last_step  (out_last_step)
);
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the ray voxel step walker (3D DDA traversal).
`timescale 1ns / 1ps
module tb;

  localparam int DIR_W      = rvsw_pkg::DIR_W;
  localparam int LEN_W      = rvsw_pkg::LEN_W;
  localparam int OFF_W      = rvsw_pkg::OFF_W;
  localparam int IDX_W      = rvsw_pkg::IDX_W;
  localparam int MAX_LEN    = rvsw_pkg::MAX_STEPS_DEF;
  localparam int QUIET_MAX  = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT = 150;   // divider pass plus a full walk

  typedef struct {
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic signed [OFF_W-1:0] off_z;
    logic [IDX_W-1:0]        idx;
    logic                    last;
  } voxel_pos_t;

  class ray_walk_board;
    voxel_pos_t pending[$];
    int mismatches;
    int rays;
    int empty_rays;
    int capped_rays;
    int positions;

    // a beats b: a is finite and b is infinite or larger
    function bit nearer(bit a_inf, bit [63:0] a_acc, bit b_inf, bit [63:0] b_acc);
      return !a_inf && (b_inf || a_acc < b_acc);
    endfunction

    // Walk the ray and queue every voxel it visits.
    function void note_ray(logic signed [DIR_W-1:0] dx, logic signed [DIR_W-1:0] dy,
                           logic signed [DIR_W-1:0] dz, logic [LEN_W-1:0] len);
      logic signed [DIR_W-1:0] dir [3];
      bit              inf [3];
      bit [63:0]       dlt [3];
      bit [63:0]       acc [3];
      int              stp [3];
      logic [OFF_W-1:0] pos [3];
      int              mag;
      int              n;
      int              ax;
      voxel_pos_t      p;
      dir[0] = dx;
      dir[1] = dy;
      dir[2] = dz;
      for (int a = 0; a < 3; a++) begin
        mag    = int'(dir[a]);
        stp[a] = (mag > 0) ? 1 : (mag < 0) ? -1 : 0;
        if (mag < 0) mag = -mag;
        inf[a] = (mag == 0);
        dlt[a] = inf[a] ? 64'd0 : (64'd1 << 31) / 64'(mag);
        acc[a] = dlt[a] >> 1;  // start at the voxel center
        pos[a] = '0;
      end
      rays++;
      n = int'(len);
      if (n == 0) empty_rays++;
      if (n > MAX_LEN) begin
        n = MAX_LEN;
        capped_rays++;
      end
      for (int i = 0; i < n; i++) begin
        p.off_x = pos[0];
        p.off_y = pos[1];
        p.off_z = pos[2];
        p.idx   = IDX_W'(i);
        p.last  = (i + 1 == n);
        pending.insert(pending.size(), p);
        // ties go to the later axis: y beats x, and z beats x and y
        if (nearer(inf[0], acc[0], inf[1], acc[1]) && nearer(inf[0], acc[0], inf[2], acc[2]))
          ax = 0;
        else if (nearer(inf[1], acc[1], inf[2], acc[2]))
          ax = 1;
        else
          ax = 2;
        pos[ax] = pos[ax] + OFF_W'(stp[ax]);
        if (!inf[ax]) acc[ax] += dlt[ax];
      end
    endfunction

    function void check_step(voxel_pos_t got);
      voxel_pos_t want;
      positions++;
      if (pending.size() == 0) begin
        $error("result transfer with no position pending: (%0d,%0d,%0d) idx %0d",
               got.off_x, got.off_y, got.off_z, got.idx);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.off_x !== want.off_x) begin
        $error("offset_x: expected %0d, got %0d", want.off_x, got.off_x);
        mismatches++;
      end
      if (got.off_y !== want.off_y) begin
        $error("offset_y: expected %0d, got %0d", want.off_y, got.off_y);
        mismatches++;
      end
      if (got.off_z !== want.off_z) begin
        $error("offset_z: expected %0d, got %0d", want.off_z, got.off_z);
        mismatches++;
      end
      if (got.idx !== want.idx) begin
        $error("step_index: expected %0d, got %0d", want.idx, got.idx);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_step: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [DIR_W-1:0] in_dir_x;
  logic signed [DIR_W-1:0] in_dir_y;
  logic signed [DIR_W-1:0] in_dir_z;
  logic [LEN_W-1:0]        in_ray_length;
  logic                    out_valid;
  logic signed [OFF_W-1:0] out_offset_x;
  logic signed [OFF_W-1:0] out_offset_y;
  logic signed [OFF_W-1:0] out_offset_z;
  logic [IDX_W-1:0]        out_step_index;
  logic                    out_last_step;

  ray_walk_board board = new();
  int            quiet;

  ray_voxel_step_walker dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .in_ray_length  (in_ray_length),
    .out_valid      (out_valid),
    .out_offset_x   (out_offset_x),
    .out_offset_y   (out_offset_y),
    .out_offset_z   (out_offset_z),
    .out_step_index (out_step_index),
    .out_last_step  (out_last_step)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    voxel_pos_t got;
    if (rst_n && out_valid) begin
      got.off_x = out_offset_x;
      got.off_y = out_offset_y;
      got.off_z = out_offset_z;
      got.idx   = out_step_index;
      got.last  = out_last_step;
      board.check_step(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("timeout: no transfer for %0d cycles", QUIET_MAX);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Hold the ray on the inputs until the block takes it.
  task automatic send_ray(logic signed [DIR_W-1:0] dx, logic signed [DIR_W-1:0] dy,
                          logic signed [DIR_W-1:0] dz, logic [LEN_W-1:0] len);
    @(negedge clk);
    start         = 1'b1;
    in_dir_x      = dx;
    in_dir_y      = dy;
    in_dir_z      = dz;
    in_ray_length = len;
    do @(posedge clk); while (busy);
    board.note_ray(dx, dy, dz, len);
  endtask

  task automatic send_vec(int dx, int dy, int dz, int len);
    send_ray(DIR_W'(dx), DIR_W'(dy), DIR_W'(dz), LEN_W'(len));
  endtask

  task automatic pause_sender();
    @(negedge clk);
    start         = 1'b0;
    in_dir_x      = DIR_W'($urandom);
    in_dir_y      = DIR_W'($urandom);
    in_dir_z      = DIR_W'($urandom);
    in_ray_length = LEN_W'($urandom);
    repeat ($urandom_range(0, 3)) @(negedge clk);
  endtask

  function automatic logic signed [DIR_W-1:0] pick_dir();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2:       return $urandom_range(0, 1) ? DIR_W'($urandom_range(1, 4))
                                           : -DIR_W'($urandom_range(1, 4));
      default: return DIR_W'($urandom);
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return LEN_W'($urandom_range(MAX_LEN + 1, 127));
      2:       return LEN_W'(MAX_LEN);
      default: return LEN_W'($urandom_range(1, 40));
    endcase
  endfunction

  initial begin
    logic signed [DIR_W-1:0] dx, dy, dz;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_dir_x      = '0;
    in_dir_y      = '0;
    in_dir_z      = '0;
    in_ray_length = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // axis extremes, zero components, ties, length corners
    send_vec(32767, 0, 0, 8);
    send_vec(-32768, 0, 0, 8);
    send_vec(0, 32767, 0, 5);
    send_vec(0, 0, -32768, 5);
    send_vec(0, 0, 0, 6);
    send_vec(1, -1, 1, 10);
    send_vec(-1, -32768, 32767, 20);
    send_vec(16384, 16384, 16384, 12);
    send_vec(16384, 16384, 0, 12);
    send_vec(-20000, 0, -20000, 12);
    send_vec(0, -12345, -12345, 9);
    send_vec(23170, -23170, 11585, 64);
    send_vec(1000, -3000, 7000, 0);
    send_vec(-5000, 2000, 300, 1);
    send_vec(9000, 9001, -9000, 65);
    send_vec(-7, 32000, -15000, 127);
    send_vec(-32768, -32768, -32768, 33);
    send_vec(32767, 32767, 32767, 64);
    send_vec(-1, 0, 0, 3);
    send_vec(12, -7, 3, 40);

    for (int i = 0; i < 500; i++) begin
      // rays 200..319 go back to back
      if ((i < 200 || i >= 320) && $urandom_range(0, 99) < 28) pause_sender();
      dx = pick_dir();
      dy = pick_dir();
      dz = pick_dir();
      // force equal accumulators now and then
      case ($urandom_range(0, 9))
        0: dy = dx;
        1: dz = -dx;
        2: begin dy = dx; dz = dx; end
        default: ;
      endcase
      send_ray(dx, dy, dz, pick_len());
    end

    @(negedge clk);
    start = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d rays sent (%0d of zero length, %0d above the step cap)",
             board.rays, board.empty_rays, board.capped_rays);
    $display("%0d voxel positions checked, %0d mismatches", board.positions,
             board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rvsw_pkg.sv
design/rvsw_div.sv
design/ray_voxel_step_walker.sv
design/rvsw_checker.sv
verif/tb.sv
